// ===== rtl/core/ple_pkg.sv =====
// Package for the positional list engine: request/response payload types,
// operation and status codes, controller/datapath command and status structs.
// No dependencies.
`default_nettype none

package ple_pkg;

    localparam int MODE_W  = 3;
    localparam int POS_W   = 9;
    localparam int VAL_W   = 32;
    localparam int ST_W    = 2;
    localparam int CNT_W   = 9;
    localparam int DEPTH_DEF = 256;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_TAIL  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_TAIL   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_INSERT     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_ERASE      = 3'd5;

    // result status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

    // decoded operation kind
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_INS  = 2'd1;
    localparam logic [1:0] KIND_REM  = 2'd2;

    // memory write address/data select
    localparam logic [1:0] WR_UP   = 2'd0;  // mem[idx+1] <= read data
    localparam logic [1:0] WR_DOWN = 2'd1;  // mem[idx]   <= read data
    localparam logic [1:0] WR_NEW  = 2'd2;  // mem[pos]   <= request value

    // memory read address select
    localparam logic RD_IDX  = 1'b0;
    localparam logic RD_NEXT = 1'b1;

    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic signed [VAL_W-1:0] removed_value;
        logic [ST_W-1:0]         status;
        logic [CNT_W-1:0]        count;
    } t_rsp;

    typedef struct packed {
        logic       ld_req;      // capture request
        logic       decode;      // load position/index, preset result
        logic       idx_inc;
        logic       idx_dec;
        logic       rd_en;
        logic       rd_sel;
        logic       wr_en;
        logic [1:0] wr_mode;
        logic       cap_removed;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       pos_eq_cnt;   // insert lands at the tail
        logic       idx_eq_pos;
        logic       idx_is_last;  // idx + 1 == count
        logic       idx_nxt_last; // idx + 2 == count
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== rtl/core/ple_dp.sv =====
// Datapath of the positional list engine: element memory, count, shift index,
// request capture, decode and response register. Uses ple_pkg.
`default_nettype none

module ple_dp
    import ple_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  t_req       i_req,
    input  t_dp_cmd    i_cmd,
    output t_dp_sts    o_sts,
    output t_rsp       o_rsp
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    logic [VAL_W-1:0]  mem [DEPTH];
    logic [VAL_W-1:0]  r_rdata;

    t_req              r_req;
    logic [CW-1:0]     r_cnt;
    logic [CW-1:0]     n_cnt;
    logic [AW-1:0]     r_idx;
    logic [AW-1:0]     n_idx;
    logic [AW-1:0]     r_pos;
    logic [VAL_W-1:0]  r_removed;
    logic [ST_W-1:0]   r_status;
    t_rsp              r_rsp;

    logic [CMPW-1:0]   cnt_ext;
    logic [CMPW-1:0]   pos_ext;
    logic [CW-1:0]     cnt_m1;
    logic              full;
    logic              empty;
    logic [1:0]        kind;
    logic [ST_W-1:0]   err;
    logic [AW-1:0]     p_eff;
    logic [CW-1:0]     idx_p1;
    logic [CW-1:0]     idx_p2;
    logic [AW-1:0]     wr_addr;
    logic [VAL_W-1:0]  wr_data;
    logic [AW-1:0]     rd_addr;

    assign cnt_ext = CMPW'(r_cnt);
    assign pos_ext = CMPW'(r_req.position);
    assign cnt_m1  = r_cnt - CW'(1);
    assign full    = (r_cnt == CW'(DEPTH));
    assign empty   = (r_cnt == '0);

    always_comb begin
        kind  = KIND_NONE;
        err   = ST_OK;
        p_eff = '0;
        case (r_req.mode)
            MODE_PUSH_FRONT: begin
                if (full) err = ST_FULL;
                else kind = KIND_INS;
            end
            MODE_PUSH_TAIL: begin
                p_eff = r_cnt[AW-1:0];
                if (full) err = ST_FULL;
                else kind = KIND_INS;
            end
            MODE_POP_FRONT: begin
                if (empty) err = ST_EMPTY;
                else kind = KIND_REM;
            end
            MODE_POP_TAIL: begin
                p_eff = cnt_m1[AW-1:0];
                if (empty) err = ST_EMPTY;
                else kind = KIND_REM;
            end
            MODE_INSERT: begin
                p_eff = pos_ext[AW-1:0];
                if (full) err = ST_FULL;
                else if (pos_ext > cnt_ext) err = ST_RANGE;
                else kind = KIND_INS;
            end
            MODE_ERASE: begin
                p_eff = pos_ext[AW-1:0];
                if (empty) err = ST_EMPTY;
                else if (pos_ext >= cnt_ext) err = ST_RANGE;
                else kind = KIND_REM;
            end
            default: begin
                kind = KIND_NONE;
            end
        endcase
    end

    assign idx_p1 = CW'(r_idx) + CW'(1);
    assign idx_p2 = CW'(r_idx) + CW'(2);

    assign o_sts.kind         = kind;
    assign o_sts.pos_eq_cnt   = (CW'(r_pos) == r_cnt);
    assign o_sts.idx_eq_pos   = (r_idx == r_pos);
    assign o_sts.idx_is_last  = (idx_p1 == r_cnt);
    assign o_sts.idx_nxt_last = (idx_p2 == r_cnt);

    always_comb begin
        case (i_cmd.wr_mode)
            WR_UP:   wr_addr = r_idx + AW'(1);
            WR_DOWN: wr_addr = r_idx;
            WR_NEW:  wr_addr = r_pos;
            default: wr_addr = r_idx;
        endcase
        wr_data = (i_cmd.wr_mode == WR_NEW) ? r_req.value : r_rdata;
        rd_addr = (i_cmd.rd_sel == RD_NEXT) ? (r_idx + AW'(1)) : r_idx;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_comb begin
        n_cnt = r_cnt;
        if (i_cmd.cnt_inc) n_cnt = r_cnt + CW'(1);
        else if (i_cmd.cnt_dec) n_cnt = r_cnt - CW'(1);

        n_idx = r_idx;
        if (i_cmd.decode) n_idx = (kind == KIND_INS) ? cnt_m1[AW-1:0] : p_eff;
        else if (i_cmd.idx_inc) n_idx = r_idx + AW'(1);
        else if (i_cmd.idx_dec) n_idx = r_idx - AW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.ld_req) begin
            r_req <= i_req;
        end
        if (i_cmd.decode) begin
            r_pos     <= p_eff;
            r_removed <= '0;
            r_status  <= err;
        end
        if (i_cmd.cap_removed) begin
            r_removed <= r_rdata;
        end
        if (i_cmd.out_load) begin
            r_rsp.removed_value <= r_removed;
            r_rsp.status        <= r_status;
            r_rsp.count         <= cnt_ext[CNT_W-1:0];
        end
    end

    assign o_rsp = r_rsp;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("element count above depth");

    a_cnt_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cnt_inc |=> (r_cnt == $past(r_cnt) + CW'(1)))
        else $error("count did not advance on insert");

    a_shift_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr_en && i_cmd.wr_mode == WR_UP) |-> (CW'(r_idx) < r_cnt))
        else $error("shift-up write from beyond the stored values");

endmodule

`default_nettype wire

// ===== rtl/core/ple_ctrl.sv =====
// Controller of the positional list engine: sequences decode, shift loops
// and response handoff; owns both handshakes. Uses ple_pkg.
`default_nettype none

module ple_ctrl
    import ple_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_req_valid,
    output logic       o_req_ready,
    output logic       o_rsp_valid,
    input  wire        i_rsp_ready,
    input  t_dp_sts    i_sts,
    output t_dp_cmd    o_cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DEC     = 4'd1;
    localparam logic [3:0] S_INS_CHK = 4'd2;
    localparam logic [3:0] S_INS_RD  = 4'd3;
    localparam logic [3:0] S_INS_WR  = 4'd4;
    localparam logic [3:0] S_INS_PUT = 4'd5;
    localparam logic [3:0] S_RM_RD   = 4'd6;
    localparam logic [3:0] S_RM_CAP  = 4'd7;
    localparam logic [3:0] S_RM_SH   = 4'd8;
    localparam logic [3:0] S_RM_WR   = 4'd9;
    localparam logic [3:0] S_FIN     = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       accept;
    logic       out_free;

    assign o_req_ready = (r_state == S_IDLE);
    assign accept      = i_req_valid && o_req_ready;
    assign out_free    = !r_out_valid || i_rsp_ready;
    assign o_rsp_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.ld_req = accept;
        case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_DEC;
            end
            S_DEC: begin
                o_cmd.decode = 1'b1;
                case (i_sts.kind)
                    KIND_INS: n_state = S_INS_CHK;
                    KIND_REM: n_state = S_RM_RD;
                    default:  n_state = S_FIN;
                endcase
            end
            S_INS_CHK: begin
                // insert at the tail needs no shifting
                if (i_sts.pos_eq_cnt) begin
                    n_state = S_INS_PUT;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_IDX;
                    n_state      = S_INS_WR;
                end
            end
            S_INS_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_IDX;
                n_state      = S_INS_WR;
            end
            S_INS_WR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_mode = WR_UP;
                if (i_sts.idx_eq_pos) begin
                    n_state = S_INS_PUT;
                end else begin
                    o_cmd.idx_dec = 1'b1;
                    n_state       = S_INS_RD;
                end
            end
            S_INS_PUT: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_mode = WR_NEW;
                o_cmd.cnt_inc = 1'b1;
                n_state       = S_FIN;
            end
            S_RM_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_IDX;
                n_state      = S_RM_CAP;
            end
            S_RM_CAP: begin
                o_cmd.cap_removed = 1'b1;
                if (i_sts.idx_is_last) begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = S_FIN;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_NEXT;
                    n_state      = S_RM_WR;
                end
            end
            S_RM_SH: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_NEXT;
                n_state      = S_RM_WR;
            end
            S_RM_WR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_mode = WR_DOWN;
                if (i_sts.idx_nxt_last) begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = S_FIN;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_RM_SH;
                end
            end
            S_FIN: begin
                // hold until the response register is free
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) n_out_valid = 1'b1;
        else if (i_rsp_ready) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_accept_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_DEC))
        else $error("accepted request not decoded next cycle");

    a_cnt_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.cnt_inc && o_cmd.cnt_dec))
        else $error("count incremented and decremented together");

    a_out_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> out_free)
        else $error("response overwritten before taken");

    a_rw_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.wr_en && o_cmd.rd_en))
        else $error("memory read and write in the same cycle");

endmodule

`default_nettype wire

// ===== rtl/core/positional_list_engine.sv =====
// Top level of the positional list engine: ordered list with push, pop,
// insert and erase. Instantiates ple_ctrl and ple_dp; uses ple_pkg.
//
//   channel  | direction | handshake                 | payload
//   request  | in        | i_req_valid / o_req_ready | i_req  (t_req)
//   response | out       | o_rsp_valid / i_rsp_ready | o_rsp  (t_rsp)
//
// One request at a time; every moved element costs one read and one write on the
// single-port element memory.
// Reset is synchronous; the list comes up empty, memory contents are not reset.
// A stalled response waits in the output register; the next request is
// accepted meanwhile and finishes once that register is free.
`default_nettype none

module positional_list_engine
    import ple_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_req_valid,
    output logic  o_req_ready,
    input  t_req  i_req,
    output logic  o_rsp_valid,
    input  wire   i_rsp_ready,
    output t_rsp  o_rsp
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    ple_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    ple_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_rsp   (o_rsp)
    );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for positional_list_engine: directed corner cases, a fill to
// capacity behind a long response stall, then random traffic under varied idling.
// Depends on ple_pkg and the RTL under rtl/core.
`timescale 1ns / 100ps

module tb_top;
    import ple_pkg::*;

    localparam int unsigned LIST_DEPTH  = DEPTH_DEF;
    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    // longest single operation shifts nearly the whole list
    localparam int unsigned TAIL_CYCLES = 2 * LIST_DEPTH + 100;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned PHASE_ITEMS = 140;

    // mode codes the block treats as no-ops
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

    class list_scoreboard;
        int unsigned capacity;
        logic signed [VAL_W-1:0] shadow_list[$];
        t_rsp expected_rsp_q[$];
        int unsigned accepted;
        int unsigned checked;
        int unsigned mismatches;
        int unsigned peak_size;

        function new(int unsigned capacity_in);
            capacity   = capacity_in;
            accepted   = 0;
            checked    = 0;
            mismatches = 0;
            peak_size  = 0;
        endfunction

        function int unsigned list_size();
            return shadow_list.size();
        endfunction

        function int unsigned pending();
            return expected_rsp_q.size();
        endfunction

        // Apply one accepted request to the shadow list and queue its response.
        function void apply_list_op(t_req req);
            t_rsp want;
            int unsigned n;
            n = shadow_list.size();
            want = '0;
            want.status = ST_OK;
            case (req.mode)
                MODE_PUSH_FRONT, MODE_PUSH_TAIL: begin
                    if (n >= capacity)
                        want.status = ST_FULL;
                    else if (req.mode == MODE_PUSH_FRONT)
                        shadow_list.push_front(req.value);
                    else
                        shadow_list.insert(shadow_list.size(), req.value);
                end
                MODE_POP_FRONT, MODE_POP_TAIL: begin
                    if (n == 0) begin
                        want.status = ST_EMPTY;
                    end else if (req.mode == MODE_POP_FRONT) begin
                        want.removed_value = shadow_list.pop_front();
                    end else begin
                        want.removed_value = shadow_list[$];
                        shadow_list.delete(shadow_list.size() - 1);
                    end
                end
                MODE_INSERT: begin
                    // full is checked ahead of the position
                    if (n >= capacity)
                        want.status = ST_FULL;
                    else if (req.position > n)
                        want.status = ST_RANGE;
                    else
                        shadow_list.insert(req.position, req.value);
                end
                MODE_ERASE: begin
                    if (n == 0) begin
                        want.status = ST_EMPTY;
                    end else if (req.position >= n) begin
                        want.status = ST_RANGE;
                    end else begin
                        want.removed_value = shadow_list[req.position];
                        shadow_list.delete(req.position);
                    end
                end
                default: ;
            endcase
            want.count = CNT_W'(shadow_list.size());
            if (shadow_list.size() > peak_size)
                peak_size = shadow_list.size();
            expected_rsp_q.insert(expected_rsp_q.size(), want);
            accepted++;
        endfunction

        function void check_response(t_rsp got);
            t_rsp want;
            if (expected_rsp_q.size() == 0) begin
                $error("unexpected response: removed_value %0d status %0d count %0d",
                       got.removed_value, got.status, got.count);
                mismatches++;
                return;
            end
            want = expected_rsp_q.pop_front();
            checked++;
            if (got.removed_value !== want.removed_value) begin
                $error("removed_value: expected %0d, got %0d",
                       want.removed_value, got.removed_value);
                mismatches++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatches++;
            end
            if (got.count !== want.count) begin
                $error("count: expected %0d, got %0d", want.count, got.count);
                mismatches++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    t_req req_data = '0;
    logic rsp_ready = 1'b0;
    logic req_ready;
    logic rsp_valid;
    t_rsp rsp_data;

    list_scoreboard sb;
    int unsigned req_idle_pct = 0;
    int unsigned rsp_idle_pct = 0;
    int unsigned rsp_hold_request = 0;
    int unsigned cycle_count = 0;

    always #1 clk = ~clk;

    positional_list_engine #(
        .DEPTH(LIST_DEPTH)
    ) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_req_valid(req_valid),
        .o_req_ready(req_ready),
        .i_req      (req_data),
        .o_rsp_valid(rsp_valid),
        .i_rsp_ready(rsp_ready),
        .o_rsp      (rsp_data)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    function automatic t_req req_of(logic [MODE_W-1:0] m, int unsigned p,
                                    logic [VAL_W-1:0] v);
        t_req r;
        r.mode     = m;
        r.position = p[POS_W-1:0];
        r.value    = v;
        return r;
    endfunction

    // Mostly legal operations steered toward a target size; the rest is noise.
    function automatic t_req random_request(int unsigned n, int unsigned goal);
        t_req r;
        int unsigned roll;
        bit grow;
        r.value = $urandom;
        if ($urandom_range(0, 99) < 6) begin
            case ($urandom_range(0, 3))
                0: r.value = VAL_MIN;
                1: r.value = VAL_MAX;
                2: r.value = '0;
                default: r.value = '1;
            endcase
        end
        r.position = POS_W'($urandom_range(0, (1 << POS_W) - 1));
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
            r.mode = MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
        end else if (roll < 14) begin
            r.mode = MODE_W'($urandom_range(MODE_PUSH_FRONT, MODE_ERASE));
        end else begin
            grow = (n < goal) ? ($urandom_range(0, 99) < 75) : ($urandom_range(0, 99) < 25);
            if (grow) begin
                case ($urandom_range(0, 2))
                    0: r.mode = MODE_PUSH_FRONT;
                    1: r.mode = MODE_PUSH_TAIL;
                    default: begin
                        r.mode     = MODE_INSERT;
                        r.position = POS_W'($urandom_range(0, n));
                    end
                endcase
            end else begin
                case ($urandom_range(0, 2))
                    0: r.mode = MODE_POP_FRONT;
                    1: r.mode = MODE_POP_TAIL;
                    default: begin
                        r.mode     = MODE_ERASE;
                        r.position = (n == 0) ? '0 : POS_W'($urandom_range(0, n - 1));
                    end
                endcase
            end
        end
        return r;
    endfunction

    task automatic send_request(input t_req r);
        while ($urandom_range(0, 99) < req_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        sb.apply_list_op(r);
    endtask

    task automatic wait_all_responses();
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic run_random(input int unsigned n_items);
        int unsigned goal;
        goal = 0;
        for (int unsigned k = 0; k < n_items; k++) begin
            if (k % 40 == 0)
                goal = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 24);
            send_request(random_request(sb.list_size(), goal));
        end
    endtask

    // response side: random stalls plus an on-demand long hold-off
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (rsp_valid && rsp_ready)
                sb.check_response(rsp_data);
            if (rsp_hold_request != 0) begin
                hold_left = rsp_hold_request;
                rsp_hold_request = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                rsp_ready <= 1'b0;
            end else begin
                rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
            end
        end
    end

    initial begin
        sb = new(LIST_DEPTH);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty-list and small-list corners
        send_request(req_of(MODE_POP_FRONT, 0, $urandom));
        send_request(req_of(MODE_POP_TAIL, 0, $urandom));
        send_request(req_of(MODE_ERASE, 0, $urandom));
        send_request(req_of(MODE_INSERT, 1, $urandom));
        send_request(req_of(MODE_INSERT, 0, VAL_MAX));
        send_request(req_of(MODE_PUSH_FRONT, 0, VAL_MIN));
        send_request(req_of(MODE_PUSH_TAIL, 0, '1));
        send_request(req_of(MODE_INSERT, 2, '0));           // at count-1
        send_request(req_of(MODE_INSERT, 4, 32'h0001_2345)); // at count: tail
        send_request(req_of(MODE_INSERT, 2, 32'h5a5a_5a5a));
        send_request(req_of(MODE_INSERT, 511, $urandom));
        send_request(req_of(MODE_ERASE, 6, $urandom));
        send_request(req_of(MODE_ERASE, 511, $urandom));
        send_request(req_of(MODE_ERASE, 0, $urandom));      // head
        send_request(req_of(MODE_ERASE, 4, $urandom));      // tail
        send_request(req_of(MODE_ERASE, 1, $urandom));
        send_request(req_of(MODE_SPARE_LO, 511, '1));
        send_request(req_of(MODE_SPARE_HI, 0, VAL_MIN));
        send_request(req_of(MODE_POP_FRONT, 0, $urandom));
        send_request(req_of(MODE_POP_TAIL, 0, $urandom));
        send_request(req_of(MODE_PUSH_TAIL, 256, '0));
        wait_all_responses();

        // fill to capacity while responses are held off; input must back up
        rsp_idle_pct = 20;
        rsp_hold_request = HOLD_CYCLES;
        while (sb.list_size() < LIST_DEPTH)
            send_request(req_of(MODE_PUSH_TAIL, $urandom_range(0, 511), $urandom));
        send_request(req_of(MODE_PUSH_FRONT, 0, $urandom));
        send_request(req_of(MODE_PUSH_TAIL, 0, $urandom));
        send_request(req_of(MODE_INSERT, 0, $urandom));
        send_request(req_of(MODE_INSERT, 511, $urandom));  // full wins over range
        send_request(req_of(MODE_ERASE, LIST_DEPTH, $urandom));
        send_request(req_of(MODE_ERASE, LIST_DEPTH - 1, $urandom));
        send_request(req_of(MODE_INSERT, LIST_DEPTH - 2, $urandom));
        send_request(req_of(MODE_ERASE, 0, $urandom));
        send_request(req_of(MODE_PUSH_FRONT, 0, $urandom));
        send_request(req_of(MODE_POP_FRONT, 0, $urandom));
        send_request(req_of(MODE_PUSH_TAIL, 0, VAL_MAX));
        send_request(req_of(MODE_POP_TAIL, 0, $urandom));
        send_request(req_of(MODE_ERASE, LIST_DEPTH / 2, $urandom));
        send_request(req_of(MODE_INSERT, LIST_DEPTH / 2, VAL_MIN));
        while (sb.list_size() > 8)
            send_request(req_of(MODE_POP_TAIL, $urandom_range(0, 511), $urandom));
        wait_all_responses();

        req_idle_pct = 20;
        rsp_idle_pct = 72;
        run_random(PHASE_ITEMS);
        wait_all_responses();

        req_idle_pct = 72;
        rsp_idle_pct = 20;
        run_random(PHASE_ITEMS);
        wait_all_responses();

        req_idle_pct = 0;
        rsp_idle_pct = 0;
        run_random(PHASE_ITEMS);
        wait_all_responses();

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("run: %0d requests, %0d responses checked, %0d mismatches",
                 sb.accepted, sb.checked, sb.mismatches);
        $display("list size peaked at %0d of %0d entries", sb.peak_size, LIST_DEPTH);
        if (sb.mismatches == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
